/* rtl/core/pulse_interval_heart_rate_meter_assert.svh */
// Assertion macros shared by the heart rate meter RTL.
`ifndef PULSE_INTERVAL_HEART_RATE_METER_ASSERT_SVH
`define PULSE_INTERVAL_HEART_RATE_METER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PHRM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heart rate meter assertion failed");

// Next-cycle implication, disabled while in reset.
`define PHRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heart rate meter assertion failed");

`endif

/* rtl/core/phrm_pkg.sv */
// Types, constants and helpers for the pulse interval heart rate meter.
`default_nettype none

package phrm_pkg;

  // Register and field widths fixed by the register map and reading format
  localparam int REG_W   = 16;
  localparam int CHAR_W  = 8;
  localparam int STAGE_W = 3;
  localparam int QUO_W   = 16;
  localparam int RATE_W  = 10;
  localparam int BCD_W   = 12;

  // Register indexes
  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_TICKS   = 1'b1
  } reg_idx_t;

  localparam logic [REG_W-1:0]  TIMEOUT_RESET = 16'd5000;
  localparam logic [REG_W-1:0]  TICKS_RESET   = 16'd60000;
  localparam logic [RATE_W-1:0] RATE_MAX      = 10'd999;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_BLANK    = 8'h20;

  // One reading as delivered on the output channel
  typedef struct packed {
    logic [CHAR_W-1:0] hundreds_char;
    logic [CHAR_W-1:0] tens_char;
    logic [CHAR_W-1:0] ones_char;
    logic              no_pulse;
  } reading_t;

  // BCD digit to ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    digit_char = CHAR_ZERO + {4'b0000, d};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/phrm_in_if.sv */
// Input channel: tick kind and sensor level, valid/ready handshake.
`default_nettype none

interface phrm_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pulse_level;

  modport source (output valid, output mode, output pulse_level, input ready);
  modport sink (input valid, input mode, input pulse_level, output ready);
endinterface

`default_nettype wire

/* rtl/core/phrm_out_if.sv */
// Output channel: one display reading, valid/ready handshake.
`default_nettype none

interface phrm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] hundreds_char;
  logic [7:0] tens_char;
  logic [7:0] ones_char;
  logic       no_pulse;

  modport source (output valid, output hundreds_char, output tens_char,
                  output ones_char, output no_pulse, input ready);
  modport sink (input valid, input hundreds_char, input tens_char,
                input ones_char, input no_pulse, output ready);
endinterface

`default_nettype wire

/* rtl/core/phrm_rate_unit.sv */
// Bit-serial divider and binary-to-BCD converter producing the rate digits.
`default_nettype none
`include "pulse_interval_heart_rate_meter_assert.svh"

module phrm_rate_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [phrm_pkg::REG_W-1:0]    dividend,
  input  logic [COUNT_BITS-1:0]         divisor,
  output logic                          busy,
  output logic                          done,
  output phrm_pkg::reading_t            result
);

  localparam int SHIFT_W = phrm_pkg::QUO_W + 1;
  localparam int CMP_W   = (COUNT_BITS > SHIFT_W) ? COUNT_BITS : SHIFT_W;
  localparam int STEP_W  = $clog2(phrm_pkg::QUO_W);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    CONVERT
  } state_t;

  state_t                          state;
  logic [STEP_W-1:0]               step;
  logic [phrm_pkg::QUO_W-1:0]      dq;    // dividend out at the top, quotient in at the bottom
  logic [phrm_pkg::QUO_W-1:0]      rem;
  logic [COUNT_BITS-1:0]           dvsr;
  logic [phrm_pkg::RATE_W-1:0]     bin;
  logic [phrm_pkg::BCD_W-1:0]      bcd;

  logic [SHIFT_W-1:0]              shifted;
  logic [CMP_W-1:0]                cmp_a;
  logic [CMP_W-1:0]                cmp_b;
  logic [CMP_W-1:0]                diff;
  logic                            ge;
  logic [phrm_pkg::QUO_W-1:0]      quo_final;
  logic [phrm_pkg::RATE_W-1:0]     rate_sat;
  logic [phrm_pkg::BCD_W-1:0]      bcd_adj;
  logic [phrm_pkg::BCD_W-1:0]      bcd_shift;

  // One restoring-division step; divisor zero always subtracts and saturates
  always_comb begin
    shifted   = {rem, dq[phrm_pkg::QUO_W-1]};
    cmp_a     = CMP_W'(shifted);
    cmp_b     = CMP_W'(dvsr);
    ge        = (cmp_a >= cmp_b);
    diff      = cmp_a - cmp_b;
    quo_final = {dq[phrm_pkg::QUO_W-2:0], ge};
    rate_sat  = (quo_final > phrm_pkg::QUO_W'(phrm_pkg::RATE_MAX)) ?
                phrm_pkg::RATE_MAX : quo_final[phrm_pkg::RATE_W-1:0];
  end

  // One double-dabble step: correct each BCD nibble, then shift in a bit
  always_comb begin
    for (int i = 0; i < phrm_pkg::BCD_W / 4; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    bcd_shift = {bcd_adj[phrm_pkg::BCD_W-2:0], bin[phrm_pkg::RATE_W-1]};
  end

  // Still busy in the cycle the result is handed over
  assign busy = (state != IDLE) || done;

  // Sequencer, datapath shift registers and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            dq    <= dividend;
            rem   <= '0;
            dvsr  <= divisor;
            step  <= STEP_W'(phrm_pkg::QUO_W - 1);
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          dq  <= quo_final;
          rem <= ge ? diff[phrm_pkg::QUO_W-1:0] : shifted[phrm_pkg::QUO_W-1:0];
          if (step == '0) begin
            bin   <= rate_sat;
            bcd   <= '0;
            step  <= STEP_W'(phrm_pkg::RATE_W - 1);
            state <= CONVERT;
          end else begin
            step <= step - 1'b1;
          end
        end
        CONVERT: begin
          bcd <= bcd_shift;
          bin <= {bin[phrm_pkg::RATE_W-2:0], 1'b0};
          if (step == '0) begin
            result.hundreds_char <= (bcd_shift[11:8] == 4'd0) ? phrm_pkg::CHAR_BLANK :
                                    phrm_pkg::digit_char(bcd_shift[11:8]);
            result.tens_char     <= phrm_pkg::digit_char(bcd_shift[7:4]);
            result.ones_char     <= phrm_pkg::digit_char(bcd_shift[3:0]);
            result.no_pulse      <= 1'b0;
            done                 <= 1'b1;
            state                <= IDLE;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `PHRM_ASSERT_NOW(a_start_when_idle, clk, rst, start, state == IDLE)
  `PHRM_ASSERT_NEXT(a_start_divides, clk, rst, start, state == DIVIDE)
  `PHRM_ASSERT_NOW(a_bcd_hundreds_digit, clk, rst, state == CONVERT, bcd[11:8] <= 4'd9)

endmodule

`default_nettype wire

/* rtl/core/pulse_interval_heart_rate_meter.sv */
// Pulse interval heart rate meter: top level with tick handling and output staging.
//
// Each transaction is either a millisecond tick or a sensor sample tick.
// A transaction that produces no reading leaves the input ready, so the next
// one can follow directly. A timeout reading (blank, no_pulse set) goes to a
// holding register at the accepting edge and from there to the output
// register, and the input is held off until the holding register is free. A
// second qualified beat starts the rate unit: bit-serial division, then
// bit-serial BCD conversion, then the done handover into the holding
// register; the input is held off until the reading leaves it. Input
// stays blocked while the holding register is occupied, which lasts as
// long as the output register waits on the reader.
`default_nettype none
`include "pulse_interval_heart_rate_meter_assert.svh"

module pulse_interval_heart_rate_meter #(
  parameter int QUALIFY_SAMPLES = 4,
  parameter int COUNT_BITS      = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  phrm_in_if.sink                     pulse,
  phrm_out_if.source                  reading,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [phrm_pkg::REG_W-1:0]  cfg_data
);

  localparam int CMP_W = (COUNT_BITS > phrm_pkg::REG_W) ? COUNT_BITS : phrm_pkg::REG_W;

  logic [phrm_pkg::REG_W-1:0]    timeout_ms;
  logic [phrm_pkg::REG_W-1:0]    ticks_per_minute;
  logic [phrm_pkg::STAGE_W-1:0]  qualify_stage;
  logic [COUNT_BITS-1:0]         interval_count;
  logic                          armed;
  logic                          pend_valid;
  phrm_pkg::reading_t            pend;
  logic                          out_valid;
  phrm_pkg::reading_t            out_data;

  logic                          accept;
  logic [COUNT_BITS-1:0]         count_inc;
  logic                          timeout_hit;
  logic                          qualified;
  logic                          beat;
  logic                          blank_emit;
  logic                          rate_start;
  logic                          rate_busy;
  logic                          rate_done;
  phrm_pkg::reading_t            rate_result;
  logic                          pend_move;
  phrm_pkg::reading_t            blank_reading;

  // Tick decode
  always_comb begin
    accept      = pulse.valid && pulse.ready;
    count_inc   = interval_count + 1'b1;
    timeout_hit = (CMP_W'(count_inc) == CMP_W'(timeout_ms));
    qualified   = (qualify_stage >= phrm_pkg::STAGE_W'(QUALIFY_SAMPLES));
    beat        = accept && pulse.mode && qualified && pulse.pulse_level;
    blank_emit  = accept && !pulse.mode && timeout_hit;
    rate_start  = beat && armed;
    pend_move   = pend_valid && (!out_valid || reading.ready);
    blank_reading.hundreds_char = phrm_pkg::CHAR_BLANK;
    blank_reading.tens_char     = phrm_pkg::CHAR_BLANK;
    blank_reading.ones_char     = phrm_pkg::CHAR_BLANK;
    blank_reading.no_pulse      = 1'b1;
  end

  assign pulse.ready           = !rate_busy && !pend_valid;
  assign reading.valid         = out_valid;
  assign reading.hundreds_char = out_data.hundreds_char;
  assign reading.tens_char     = out_data.tens_char;
  assign reading.ones_char     = out_data.ones_char;
  assign reading.no_pulse      = out_data.no_pulse;

  // Divider and digit conversion
  phrm_rate_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_rate (
    .clk      (clk),
    .rst      (rst),
    .start    (rate_start),
    .dividend (ticks_per_minute),
    .divisor  (interval_count),
    .busy     (rate_busy),
    .done     (rate_done),
    .result   (rate_result)
  );

  // Registers, meter state and output staging control
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms       <= phrm_pkg::TIMEOUT_RESET;
      ticks_per_minute <= phrm_pkg::TICKS_RESET;
      qualify_stage    <= '0;
      interval_count   <= '0;
      armed            <= 1'b0;
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (phrm_pkg::reg_idx_t'(cfg_index))
          phrm_pkg::REG_TIMEOUT: timeout_ms       <= cfg_data;
          phrm_pkg::REG_TICKS:   ticks_per_minute <= cfg_data;
          default: ;
        endcase
      end

      // Holding register to output register
      if (pend_move) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (reading.ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        if (!pulse.mode) begin
          if (timeout_hit) begin
            interval_count <= '0;
            armed          <= 1'b0;
            pend_valid     <= 1'b1;
          end else begin
            interval_count <= count_inc;
          end
        end else if (!qualified) begin
          qualify_stage <= pulse.pulse_level ? '0 : qualify_stage + 1'b1;
        end else if (pulse.pulse_level) begin
          // released beat: first arms, second measures
          qualify_stage  <= '0;
          interval_count <= '0;
          armed          <= !armed;
        end
      end

      if (rate_done) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // Reading payload
  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_data <= pend;
    end
    if (blank_emit) begin
      pend <= blank_reading;
    end else if (rate_done) begin
      pend <= rate_result;
    end
  end

  `PHRM_ASSERT_NOW(a_done_into_free_slot, clk, rst, rate_done, !pend_valid)
  `PHRM_ASSERT_NOW(a_rate_never_leading_zero, clk, rst, reading.valid && !reading.no_pulse,
                   reading.hundreds_char != phrm_pkg::CHAR_ZERO)
  `PHRM_ASSERT_NEXT(a_blank_staged, clk, rst, blank_emit,
                    pend_valid && pend.no_pulse)

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the pulse interval heart rate meter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUALIFY_SAMPLES = 4;
  localparam int COUNT_BITS      = 16;

  // Tick kinds and sensor levels (sensor is active low)
  localparam logic MODE_MS     = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;
  localparam logic LEVEL_LOW   = 1'b0;
  localparam logic LEVEL_HIGH  = 1'b1;

  // Settling time after the last reading before a register write or the end
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic mode;
    logic pulse_level;
  } tick_t;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [0:0]                   cfg_index;
  logic [phrm_pkg::REG_W-1:0]   cfg_data;

  phrm_in_if  pulse_ch ();
  phrm_out_if reading_ch ();

  pulse_interval_heart_rate_meter #(
    .QUALIFY_SAMPLES(QUALIFY_SAMPLES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .pulse    (pulse_ch),
    .reading  (reading_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Ticks waiting to be sent and readings waiting to arrive
  tick_t                pending_ticks[$];
  phrm_pkg::reading_t   expected_readings[$];
  int unsigned          ticks_taken;
  int unsigned          mismatch_count;

  // Meter model: registers and state
  logic [phrm_pkg::REG_W-1:0]   timeout_reg = phrm_pkg::TIMEOUT_RESET;
  logic [phrm_pkg::REG_W-1:0]   ticks_reg   = phrm_pkg::TICKS_RESET;
  logic [phrm_pkg::STAGE_W-1:0] low_run     = '0;
  logic [COUNT_BITS-1:0]        interval_ms = '0;
  logic                         armed       = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle percentage by stage of the run: receiver-light, then sender-light, then none
  function automatic int unsigned idle_pct(input bit receiver);
    if (ticks_taken < 600) return receiver ? 76 : 29;
    if (ticks_taken < 1200) return receiver ? 29 : 76;
    return 0;
  endfunction

  // Advance the meter model by one tick; returns 1 when a reading results
  function automatic bit meter_step(input tick_t t, output phrm_pkg::reading_t rd);
    logic [phrm_pkg::REG_W-1:0] quo;
    int unsigned                rate;
    int unsigned                hundreds;
    rd = '0;
    // Millisecond tick: count, declare no pulse on reaching the timeout
    if (t.mode == MODE_MS) begin
      interval_ms = interval_ms + 1'b1;
      if (interval_ms == timeout_reg) begin
        interval_ms = '0;
        armed = 1'b0;
        rd = '{phrm_pkg::CHAR_BLANK, phrm_pkg::CHAR_BLANK, phrm_pkg::CHAR_BLANK, 1'b1};
        return 1'b1;
      end
      return 1'b0;
    end
    // Qualifier: run of low samples, a high one below the threshold restarts it
    if (low_run < QUALIFY_SAMPLES) begin
      low_run = (t.pulse_level == LEVEL_LOW) ? low_run + 1'b1 : '0;
      return 1'b0;
    end
    if (t.pulse_level == LEVEL_LOW) return 1'b0;
    // Release after a qualified run: a beat
    low_run = '0;
    if (!armed) begin
      interval_ms = '0;
      armed = 1'b1;
      return 1'b0;
    end
    if (interval_ms == '0) begin
      rate = 32'(phrm_pkg::RATE_MAX);
    end else begin
      quo  = ticks_reg / interval_ms;
      rate = (quo > phrm_pkg::REG_W'(phrm_pkg::RATE_MAX)) ?
             32'(phrm_pkg::RATE_MAX) : 32'(quo);
    end
    hundreds = rate / 100;
    rd.hundreds_char = (hundreds == 0) ? phrm_pkg::CHAR_BLANK :
                       phrm_pkg::CHAR_ZERO + phrm_pkg::CHAR_W'(hundreds);
    rd.tens_char     = phrm_pkg::CHAR_ZERO + phrm_pkg::CHAR_W'((rate % 100) / 10);
    rd.ones_char     = phrm_pkg::CHAR_ZERO + phrm_pkg::CHAR_W'(rate % 10);
    rd.no_pulse      = 1'b0;
    interval_ms = '0;
    armed = 1'b0;
    return 1'b1;
  endfunction

  // Sender: predict on each accepted transaction, then offer the next tick
  always @(posedge clk) begin : drive_ticks
    tick_t              taken;
    tick_t              nxt;
    phrm_pkg::reading_t rd;
    if (rst) begin
      pulse_ch.valid <= 1'b0;
    end else begin
      if (pulse_ch.valid && pulse_ch.ready) begin
        taken = '{mode: pulse_ch.mode, pulse_level: pulse_ch.pulse_level};
        if (meter_step(taken, rd)) expected_readings.push_back(rd);
        ticks_taken++;
      end
      if (!pulse_ch.valid || pulse_ch.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          nxt = pending_ticks.pop_front();
          pulse_ch.valid       <= 1'b1;
          pulse_ch.mode        <= nxt.mode;
          pulse_ch.pulse_level <= nxt.pulse_level;
        end else begin
          pulse_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted reading against the oldest expectation
  always @(posedge clk) begin : check_readings
    phrm_pkg::reading_t got;
    phrm_pkg::reading_t want;
    if (rst) begin
      reading_ch.ready <= 1'b0;
    end else begin
      if (reading_ch.valid && reading_ch.ready) begin
        got = '{reading_ch.hundreds_char, reading_ch.tens_char,
                reading_ch.ones_char, reading_ch.no_pulse};
        if (expected_readings.size() == 0) begin
          $error("reading with none expected: %h", got);
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          if (got.hundreds_char !== want.hundreds_char) begin
            $error("hundreds_char: expected %h, got %h", want.hundreds_char, got.hundreds_char);
            mismatch_count++;
          end
          if (got.tens_char !== want.tens_char) begin
            $error("tens_char: expected %h, got %h", want.tens_char, got.tens_char);
            mismatch_count++;
          end
          if (got.ones_char !== want.ones_char) begin
            $error("ones_char: expected %h, got %h", want.ones_char, got.ones_char);
            mismatch_count++;
          end
          if (got.no_pulse !== want.no_pulse) begin
            $error("no_pulse: expected %b, got %b", want.no_pulse, got.no_pulse);
            mismatch_count++;
          end
        end
      end
      reading_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  function automatic void queue_tick(input logic m, input logic lvl);
    pending_ticks.push_back(tick_t'{mode: m, pulse_level: lvl});
  endfunction

  // A qualified beat: a run of low samples and a release
  function automatic void queue_beat(input int unsigned lows);
    repeat (lows) queue_tick(MODE_SAMPLE, LEVEL_LOW);
    queue_tick(MODE_SAMPLE, LEVEL_HIGH);
  endfunction

  // Mostly well-formed beats with random intervals, some broken runs and noise
  function automatic void queue_traffic(input int unsigned n_items, input int unsigned max_gap);
    int unsigned pick;
    int unsigned lows;
    int unsigned gap;
    while (pending_ticks.size() < n_items) begin
      pick = $urandom_range(99);
      if (pick < 88) begin
        lows = (pick < 75) ? QUALIFY_SAMPLES + $urandom_range(2) : $urandom_range(1, 3);
        repeat (lows) begin
          if ($urandom_range(4) == 0) queue_tick(MODE_MS, logic'($urandom_range(1)));
          queue_tick(MODE_SAMPLE, LEVEL_LOW);
        end
        queue_tick(MODE_SAMPLE, LEVEL_HIGH);
        gap = ($urandom_range(7) == 0) ? $urandom_range(max_gap) : $urandom_range(max_gap / 4);
        repeat (gap) queue_tick(MODE_MS, logic'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 6))
          queue_tick(logic'($urandom_range(1)), logic'($urandom_range(1)));
      end
    end
  endfunction

  // Hold off until everything is sent and every reading has come back
  task automatic drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || pulse_ch.valid || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic set_config(input logic [phrm_pkg::REG_W-1:0] timeout,
                            input logic [phrm_pkg::REG_W-1:0] ticks);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= phrm_pkg::REG_TIMEOUT;
    cfg_data  <= timeout;
    timeout_reg = timeout;
    @(posedge clk);
    cfg_index <= phrm_pkg::REG_TICKS;
    cfg_data  <= ticks;
    ticks_reg = ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Run sequence
  initial begin : run_phases
    rst                  = 1'b1;
    pulse_ch.valid       = 1'b0;
    pulse_ch.mode        = MODE_MS;
    pulse_ch.pulse_level = LEVEL_HIGH;
    reading_ch.ready     = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = phrm_pkg::REG_TIMEOUT;
    cfg_data             = '0;
    ticks_taken          = 0;
    mismatch_count       = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: high before qualified, low while qualified, zero interval, saturation
    queue_tick(MODE_SAMPLE, LEVEL_LOW);
    queue_tick(MODE_SAMPLE, LEVEL_LOW);
    queue_tick(MODE_SAMPLE, LEVEL_HIGH);
    queue_beat(QUALIFY_SAMPLES + 1);
    queue_beat(QUALIFY_SAMPLES);
    queue_beat(QUALIFY_SAMPLES);
    queue_tick(MODE_MS, LEVEL_HIGH);
    queue_beat(QUALIFY_SAMPLES);
    queue_traffic(175, 120);
    drain();

    // Timeout on every millisecond, largest dividend
    set_config(16'd1, 16'd65535);
    queue_traffic(100, 4);
    drain();

    // Short timeout, rates spread over two and three digits
    set_config(16'd40, 16'd700);
    queue_traffic(600, 60);
    drain();

    // Longest timeout, smallest dividend: readings of zero, one and the saturated 999
    set_config(16'd65535, 16'd1);
    queue_traffic(150, 3);
    drain();

    set_config(16'd300, 16'd9000);
    queue_traffic(400, 150);
    drain();

    // Timeout of zero: the counter never wraps here, so no timeout fires
    set_config(16'd0, 16'd6000);
    queue_beat(QUALIFY_SAMPLES);
    repeat (7) queue_tick(MODE_MS, LEVEL_LOW);
    queue_beat(QUALIFY_SAMPLES);
    queue_traffic(60, 100);
    drain();

    // Back to reset values
    set_config(phrm_pkg::TIMEOUT_RESET, phrm_pkg::TICKS_RESET);
    queue_traffic(250, 80);
    drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/phrm_pkg.sv
rtl/core/phrm_in_if.sv
rtl/core/phrm_out_if.sv
rtl/core/phrm_rate_unit.sv
rtl/core/pulse_interval_heart_rate_meter.sv
sim/tb_top.sv
